FILE: rtl/gha_pkg.sv
package gha_pkg;

    // Default geometry
    localparam int SLOTS_DEFAULT    = 64;
    localparam int GEN_BITS_DEFAULT = 8;

    // Handle layout
    localparam int HANDLE_W    = 32;
    localparam int INDEX_BITS  = 24;
    localparam int GEN_FIELD_W = 8;
    localparam logic [HANDLE_W-1:0] NO_HANDLE = '1;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] RECYCLE_THRESHOLD_RST = 7'd32;
    localparam logic [CFG_W-1:0] DEFAULT_LIMIT_RST     = 7'd2;
    localparam logic [CFG_W-1:0] MAX_LIMIT_RST         = 7'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC    = 2'd0,
        KIND_VALIDATE = 2'd1,
        KIND_RELEASE  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_LIMIT   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECYCLE_THRESHOLD = 2'd0,
        CFG_DEFAULT_LIMIT     = 2'd1,
        CFG_MAX_LIMIT         = 2'd2
    } cfg_reg_t;

endpackage

FILE: rtl/gha_if.sv
interface gha_req_if;
    logic                             valid;
    logic                             ready;
    logic [gha_pkg::KIND_W-1:0]       kind;
    logic [gha_pkg::HANDLE_W-1:0]     handle;
    logic                             force_new;

    modport source (output valid, kind, handle, force_new, input ready);
    modport sink   (input valid, kind, handle, force_new, output ready);
endinterface

interface gha_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [gha_pkg::STATUS_W-1:0]     status;
    logic [gha_pkg::HANDLE_W-1:0]     handle_out;
    logic [gha_pkg::LIVE_W-1:0]       live_count;

    modport source (output valid, status, handle_out, live_count, input ready);
    modport sink   (input valid, status, handle_out, live_count, output ready);
endinterface

FILE: rtl/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read at the write address returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/generational_handle_allocator.sv
// Channel  Dir  Payload                              Transfer
// req      in   kind, handle, force_new              req.valid & req.ready
// rsp      out  status, handle_out, live_count       rsp.valid & rsp.ready
// cfg      in   cfg_index, cfg_data                  cfg_we
//
// One request per cycle while req.ready is high. The accepting edge captures the
// registered table and free-list reads; the decide stage then resolves the request,
// writes back and loads the output register, from which the result transfers. Writes of the previous
// request are forwarded. Reset clears counters and pointers and restores the register
// defaults; the slot table and free list need no clearing pass, since entries are
// read only once written.
// A stalled rsp holds the output register, then the decide stage, then req.ready.
module generational_handle_allocator #(
    parameter int SLOTS    = gha_pkg::SLOTS_DEFAULT,
    parameter int GEN_BITS = gha_pkg::GEN_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gha_req_if.sink                         req,
    gha_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [gha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gha_pkg::CFG_W-1:0]       cfg_data
);

    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CMP_W     = (CNT_W > gha_pkg::CFG_W) ? CNT_W : gha_pkg::CFG_W;
    localparam int IDX_CMP_W = (CNT_W > gha_pkg::INDEX_BITS) ? CNT_W : gha_pkg::INDEX_BITS;
    localparam int ENTRY_W   = GEN_BITS + 1;
    localparam int FIFO_W    = ADDR_W + GEN_BITS;
    localparam int HW        = gha_pkg::HANDLE_W;
    localparam int IB        = gha_pkg::INDEX_BITS;

    // Configuration
    logic [gha_pkg::CFG_W-1:0] thr_reg;
    logic [gha_pkg::CFG_W-1:0] dflt_reg;
    logic [gha_pkg::CFG_W-1:0] max_reg;

    // Allocator state
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [CNT_W-1:0]  live_reg, live_next;

    // Decide stage
    logic                          s1_valid_reg;
    logic [gha_pkg::KIND_W-1:0]    s1_kind_reg;
    logic [HW-1:0]                 s1_handle_reg;
    logic                          s1_force_reg;

    // Output register
    logic                          out_valid_reg;
    gha_pkg::status_t              out_status_reg, status_next;
    logic [HW-1:0]                 out_handle_reg, hout_next;
    logic [gha_pkg::LIVE_W-1:0]    out_live_reg;

    // Forwarding of the write that coincides with the current item's reads
    logic                 gen_fwd_valid_reg;
    logic [ADDR_W-1:0]    gen_fwd_addr_reg;
    logic [ENTRY_W-1:0]   gen_fwd_data_reg;
    logic                 fifo_fwd_valid_reg;
    logic [ADDR_W-1:0]    fifo_fwd_addr_reg;
    logic [FIFO_W-1:0]    fifo_fwd_data_reg;
    logic [ADDR_W-1:0]    fifo_raddr_reg;

    // Memory ports
    logic                 gen_we;
    logic [ADDR_W-1:0]    gen_waddr;
    logic [ENTRY_W-1:0]   gen_wdata;
    logic [ENTRY_W-1:0]   gen_rdata;
    logic                 fifo_we;
    logic [FIFO_W-1:0]    fifo_wdata;
    logic [FIFO_W-1:0]    fifo_rdata;
    logic [ADDR_W-1:0]    fifo_raddr;

    // Handshake
    logic accept;
    logic s1_move;

    // Decide-stage intermediates
    logic [ENTRY_W-1:0]   gen_entry;
    logic [FIFO_W-1:0]    fifo_entry;
    logic [ADDR_W-1:0]    h_addr;
    logic [GEN_BITS-1:0]  h_gen_cur;
    logic                 h_live;
    logic                 handle_ok;
    logic                 limit_ok;
    logic                 recycle;
    logic [ADDR_W-1:0]    alloc_idx;
    logic [GEN_BITS-1:0]  alloc_gen;
    logic                 alloc_ok;
    logic                 release_ok;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    // Read at the head as it stands after this edge's commit
    assign fifo_raddr = s1_move ? head_next : head_reg;

    gha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (accept),
        .raddr (req.handle[ADDR_W-1:0]),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (FIFO_W),
        .DEPTH (SLOTS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (fifo_wdata),
        .re    (accept),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // Decide the request and compute the state after it
    always_comb
    begin
        h_addr     = s1_handle_reg[ADDR_W-1:0];
        gen_entry  = (gen_fwd_valid_reg && gen_fwd_addr_reg == h_addr)
                     ? gen_fwd_data_reg : gen_rdata;
        fifo_entry = (fifo_fwd_valid_reg && fifo_fwd_addr_reg == fifo_raddr_reg)
                     ? fifo_fwd_data_reg : fifo_rdata;
        h_gen_cur  = gen_entry[GEN_BITS-1:0];
        h_live     = gen_entry[GEN_BITS];

        handle_ok = (s1_handle_reg != gha_pkg::NO_HANDLE)
                 && (IDX_CMP_W'(s1_handle_reg[IB-1:0]) < IDX_CMP_W'(issued_reg))
                 && (s1_handle_reg[HW-1:IB] == gha_pkg::GEN_FIELD_W'(h_gen_cur));

        limit_ok = (CMP_W'(live_reg) < CMP_W'(dflt_reg))
                || (s1_force_reg && (CMP_W'(live_reg) < CMP_W'(max_reg)));
        recycle  = (CMP_W'(free_cnt_reg) > CMP_W'(thr_reg)) && (free_cnt_reg != '0);

        head_next     = head_reg;
        tail_next     = tail_reg;
        free_cnt_next = free_cnt_reg;
        issued_next   = issued_reg;
        live_next     = live_reg;
        status_next   = gha_pkg::STATUS_INVALID;
        hout_next     = gha_pkg::NO_HANDLE;
        alloc_idx     = issued_reg[ADDR_W-1:0];
        alloc_gen     = '0;
        alloc_ok      = 1'b0;
        release_ok    = 1'b0;

        unique case (s1_kind_reg)
            gha_pkg::KIND_ALLOC:
            begin
                if (!limit_ok)
                begin
                    status_next = gha_pkg::STATUS_LIMIT;
                end
                else if (recycle)
                begin
                    alloc_idx     = fifo_entry[FIFO_W-1:GEN_BITS];
                    alloc_gen     = fifo_entry[GEN_BITS-1:0];
                    alloc_ok      = 1'b1;
                    head_next     = (head_reg == ADDR_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                    free_cnt_next = free_cnt_reg - 1'b1;
                end
                else if (issued_reg < CNT_W'(SLOTS))
                begin
                    alloc_ok    = 1'b1;
                    issued_next = issued_reg + 1'b1;
                end
                else
                begin
                    status_next = gha_pkg::STATUS_FULL;
                end
                if (alloc_ok)
                begin
                    live_next   = live_reg + 1'b1;
                    status_next = gha_pkg::STATUS_OK;
                    hout_next   = {gha_pkg::GEN_FIELD_W'(alloc_gen), IB'(alloc_idx)};
                end
            end
            gha_pkg::KIND_VALIDATE:
            begin
                status_next = handle_ok ? gha_pkg::STATUS_OK : gha_pkg::STATUS_INVALID;
            end
            gha_pkg::KIND_RELEASE:
            begin
                release_ok = handle_ok && h_live && (live_reg != '0)
                          && (free_cnt_reg < CNT_W'(SLOTS));
                if (release_ok)
                begin
                    live_next     = live_reg - 1'b1;
                    tail_next     = (tail_reg == ADDR_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                    free_cnt_next = free_cnt_reg + 1'b1;
                    status_next   = gha_pkg::STATUS_OK;
                end
            end
            default:
            begin
                status_next = gha_pkg::STATUS_INVALID;
            end
        endcase

        // Table write: mark live on allocate, bump generation and clear live on release
        gen_we    = s1_move && (alloc_ok || release_ok);
        gen_waddr = release_ok ? h_addr : alloc_idx;
        gen_wdata = release_ok ? {1'b0, GEN_BITS'(h_gen_cur + 1'b1)} : {1'b1, alloc_gen};

        // Queue the freed slot along with its new generation
        fifo_we    = s1_move && release_ok;
        fifo_wdata = {h_addr, GEN_BITS'(h_gen_cur + 1'b1)};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg            <= gha_pkg::RECYCLE_THRESHOLD_RST;
            dflt_reg           <= gha_pkg::DEFAULT_LIMIT_RST;
            max_reg            <= gha_pkg::MAX_LIMIT_RST;
            head_reg           <= '0;
            tail_reg           <= '0;
            free_cnt_reg       <= '0;
            issued_reg         <= '0;
            live_reg           <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            gen_fwd_valid_reg  <= 1'b0;
            fifo_fwd_valid_reg <= 1'b0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gha_pkg::CFG_RECYCLE_THRESHOLD: thr_reg  <= cfg_data;
                    gha_pkg::CFG_DEFAULT_LIMIT:     dflt_reg <= cfg_data;
                    gha_pkg::CFG_MAX_LIMIT:         max_reg  <= cfg_data;
                    default:                        ;
                endcase
            end

            // Commit the decided request
            if (s1_move)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                free_cnt_reg <= free_cnt_next;
                issued_reg   <= issued_next;
                live_reg     <= live_next;
            end

            // Advance the pipeline
            if (accept)
            begin
                s1_valid_reg       <= 1'b1;
                gen_fwd_valid_reg  <= gen_we;
                fifo_fwd_valid_reg <= fifo_we;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg       <= req.kind;
            s1_handle_reg     <= req.handle;
            s1_force_reg      <= req.force_new;
            gen_fwd_addr_reg  <= gen_waddr;
            gen_fwd_data_reg  <= gen_wdata;
            fifo_fwd_addr_reg <= tail_reg;
            fifo_fwd_data_reg <= fifo_wdata;
            fifo_raddr_reg    <= fifo_raddr;
        end
        if (s1_move)
        begin
            out_status_reg <= status_next;
            out_handle_reg <= hout_next;
            out_live_reg   <= gha_pkg::LIVE_W'(CMP_W'(live_next));
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.live_count = out_live_reg;

`ifndef NO_ASSERTIONS
    // Every issued slot is either live or waiting in the free list
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(live_reg) + (CNT_W + 1)'(free_cnt_reg) == (CNT_W + 1)'(issued_reg))
        else $error("live plus free slots differ from issued slots");

    // An empty free list has its pointers together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg == '0 |-> head_reg == tail_reg)
        else $error("free list empty with head and tail apart");

    // Only a successful request carries a handle
    a_handle_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != gha_pkg::STATUS_OK |-> rsp.handle_out == gha_pkg::NO_HANDLE)
        else $error("failed request returned a handle");

    // State changes only on a commit
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(issued_reg) && $stable(live_reg) && $stable(free_cnt_reg))
        else $error("allocator state changed without a committed request");
`endif

endmodule
